>>> rtl/mpeg_audio_header_sync_parser_unit_macros.svh
// Assertion macros for the MPEG audio header sync parser.
// Used by the top level; the checks compile away when SYNTHESIS is defined.
`ifndef MPEG_AUDIO_HEADER_SYNC_PARSER_UNIT_MACROS_SVH
`define MPEG_AUDIO_HEADER_SYNC_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MAHSP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mahsp assertion failed");
`define MAHSP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mahsp assertion failed");
`else
`define MAHSP_ASSERT(label, clk, rst, prop)
`define MAHSP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> rtl/mahsp_pkg.sv
// Types, constants and lookup tables for the MPEG audio header sync parser.
// Has no dependencies; used by mahsp_decode and the top level.
`default_nettype none

package mahsp_pkg;

   localparam logic [7:0]  SYNC_LEAD       = 8'hFF;
   localparam logic [7:0]  SYNC_CODE_FA    = 8'hFA;
   localparam logic [7:0]  SYNC_CODE_F3    = 8'hF3;
   localparam logic [7:0]  SYNC_CODE_F5    = 8'hF5;
   localparam logic [7:0]  SYNC_CODE_FB    = 8'hFB;
   localparam logic [7:0]  SYNC_CODE_FC    = 8'hFC;
   localparam logic [7:0]  SYNC_CODE_FD    = 8'hFD;

   localparam logic [1:0]  VERSION_MPEG1   = 2'b11;
   localparam logic [1:0]  LAYER_CODE_1    = 2'b11;
   localparam logic [1:0]  LAYER_CODE_3    = 2'b01;
   localparam logic [1:0]  MODE_MONO       = 2'b11;

   localparam logic [15:0] SCAN_LIMIT_RESET = 16'd16384;

   localparam logic        STATUS_FOUND     = 1'b0;
   localparam logic        STATUS_NOT_FOUND = 1'b1;

   // Byte rates (125 times kbit/s), indexed by the bitrate index.
   localparam logic [15:0] MP1_L12_BYTE_RATE [16] = '{
      16'd0,     16'd4000,  16'd6000,  16'd7000,  16'd8000,  16'd10000, 16'd12000, 16'd14000,
      16'd16000, 16'd20000, 16'd24000, 16'd28000, 16'd32000, 16'd40000, 16'd48000, 16'd0};
   localparam logic [15:0] MP1_L3_BYTE_RATE [16] = '{
      16'd0,     16'd4000,  16'd5000,  16'd6000,  16'd7000,  16'd8000,  16'd10000, 16'd12000,
      16'd14000, 16'd16000, 16'd20000, 16'd24000, 16'd28000, 16'd32000, 16'd40000, 16'd0};
   localparam logic [15:0] MP2_L1_BYTE_RATE [16] = '{
      16'd0,     16'd4000,  16'd6000,  16'd7000,  16'd8000,  16'd10000, 16'd12000, 16'd14000,
      16'd16000, 16'd18000, 16'd20000, 16'd22000, 16'd24000, 16'd28000, 16'd32000, 16'd0};
   localparam logic [15:0] MP2_L23_BYTE_RATE [16] = '{
      16'd0,     16'd1000,  16'd2000,  16'd3000,  16'd4000,  16'd5000,  16'd6000,  16'd7000,
      16'd8000,  16'd10000, 16'd12000, 16'd14000, 16'd16000, 16'd18000, 16'd20000, 16'd0};

   localparam logic [15:0] MP1_HZ [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
   localparam logic [15:0] MP2_HZ [4] = '{16'd22050, 16'd24000, 16'd16000, 16'd0};

   typedef struct packed {
      logic        valid;
      logic [1:0]  channels;
      logic [15:0] frequency_hz;
      logic [15:0] byte_rate;
      logic        is_mp3;
   } hdr_info_type;

   function automatic logic is_sync_code(input logic [7:0] b);
      is_sync_code = (b == SYNC_CODE_FA) || (b == SYNC_CODE_F3) || (b == SYNC_CODE_F5) ||
                     (b == SYNC_CODE_FB) || (b == SYNC_CODE_FC) || (b == SYNC_CODE_FD);
   endfunction

endpackage

`default_nettype wire

>>> rtl/mahsp_decode.sv
// Header decoder: turns the three header bytes into a valid flag, channel count,
// sample rate, byte rate and the MPEG-1 layer 3 flag. Uses mahsp_pkg for its tables.
`default_nettype none

module mahsp_decode
   import mahsp_pkg::*;
(
   input  wire logic [7:0]   sync_byte,
   input  wire logic [7:0]   rate_byte,
   input  wire logic [7:0]   mode_byte,
   output hdr_info_type      info
);

   logic        mpeg1;
   logic        layer1;
   logic        layer3;
   logic [3:0]  bitrate_idx;
   logic [1:0]  freq_idx;
   logic [15:0] byte_rate;
   logic [15:0] freq_hz;

   assign mpeg1       = (sync_byte[4:3] == VERSION_MPEG1);
   assign layer1      = (sync_byte[2:1] == LAYER_CODE_1);
   assign layer3      = (sync_byte[2:1] == LAYER_CODE_3);
   assign bitrate_idx = rate_byte[7:4];
   assign freq_idx    = rate_byte[3:2];

   // MPEG-2 layer 3 shares the layer 2 bitrate table.
   always_comb begin
      if (mpeg1) begin
         byte_rate = layer3 ? MP1_L3_BYTE_RATE[bitrate_idx] : MP1_L12_BYTE_RATE[bitrate_idx];
         freq_hz   = MP1_HZ[freq_idx];
      end else begin
         byte_rate = layer1 ? MP2_L1_BYTE_RATE[bitrate_idx] : MP2_L23_BYTE_RATE[bitrate_idx];
         freq_hz   = MP2_HZ[freq_idx];
      end
   end

   assign info.valid        = (byte_rate != 16'd0) && (freq_hz != 16'd0);
   assign info.channels     = (mode_byte[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
   assign info.frequency_hz = freq_hz;
   assign info.byte_rate    = byte_rate;
   assign info.is_mp3       = mpeg1 & layer3;

endmodule

`default_nettype wire

>>> rtl/mpeg_audio_header_sync_parser_unit.sv
// MPEG audio header sync parser: hunts a byte stream for a frame sync and
// reports the first valid header, or a not-found word once the scan limit runs out.
// An accepted byte goes through the input register, then the result register, to its
// result word. Throughput: one byte per cycle while rsp_tready is high.
// Synchronous reset clears the hunt state and sets scan_limit to 16384.
// Depends on mahsp_pkg, mahsp_decode and the assertion macro header.
`default_nettype none
`include "mpeg_audio_header_sync_parser_unit_macros.svh"

module mpeg_audio_header_sync_parser_unit
   import mahsp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [7:0]   req_tdata,    // data_byte
   input  wire logic         req_tuser,    // start_of_buffer

   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // channels[1:0], frequency_hz[17:2], byte_rate[33:18], is_mp3[34],
   // sync_byte[42:35], rate_byte[50:43], mode_byte[58:51], zero fill[63:59]
   output      logic [63:0]  rsp_tdata,
   output      logic         rsp_tuser,    // status

   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data   // scan_limit
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_AFTER,
      PH_RATE,
      PH_MODE
   } phase_type;

   // Input register
   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_start_ff;

   // Hunt state
   phase_type    phase_ff,     phase_in;
   logic [15:0]  count_ff,     count_in;
   logic [7:0]   held_sync_ff, held_sync_in;
   logic         held_sync_we;
   logic [7:0]   held_rate_ff, held_rate_in;
   logic         held_rate_we;
   logic         finished_ff,  finished_in;
   logic [15:0]  scan_limit_ff;

   // Result register
   logic         out_valid_ff,   out_valid_in;
   logic         out_load;
   logic         out_status_ff,  out_status_in;
   logic [1:0]   out_chan_ff,    out_chan_in;
   logic [15:0]  out_freq_ff,    out_freq_in;
   logic [15:0]  out_brate_ff,   out_brate_in;
   logic         out_mp3_ff,     out_mp3_in;
   logic [7:0]   out_sync_ff,    out_sync_in;
   logic [7:0]   out_rate_ff,    out_rate_in;
   logic [7:0]   out_mode_ff,    out_mode_in;

   logic         advance;
   phase_type    phase_cur;
   logic [15:0]  count_cur;
   logic         finished_cur;
   logic         end_iter;
   logic [15:0]  last_iter;
   hdr_info_type hdr_info;

   mahsp_decode u_decode (
      .sync_byte (held_sync_ff),
      .rate_byte (held_rate_ff),
      .mode_byte (in_byte_ff),
      .info      (hdr_info)
   );

   // The held word moves on only when the result register is free or being emptied.
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   // A zero limit wraps here, which allows the full 65536 iterations.
   assign last_iter    = scan_limit_ff - 16'd1;

   assign phase_cur    = in_start_ff ? PH_HUNT : phase_ff;
   assign count_cur    = in_start_ff ? 16'd0   : count_ff;
   assign finished_cur = in_start_ff ? 1'b0    : finished_ff;

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      finished_in   = finished_ff;
      held_sync_in  = in_byte_ff;
      held_sync_we  = 1'b0;
      held_rate_in  = in_byte_ff;
      held_rate_we  = 1'b0;
      end_iter      = 1'b0;
      out_valid_in  = out_valid_ff & ~rsp_tready;
      out_load      = 1'b0;
      out_status_in = STATUS_NOT_FOUND;
      out_chan_in   = 2'd0;
      out_freq_in   = 16'd0;
      out_brate_in  = 16'd0;
      out_mp3_in    = 1'b0;
      out_sync_in   = 8'd0;
      out_rate_in   = 8'd0;
      out_mode_in   = 8'd0;

      if (advance) begin
         phase_in    = phase_cur;
         count_in    = count_cur;
         finished_in = finished_cur;
         if (!finished_cur) begin
            case (phase_cur)
               PH_HUNT: begin
                  if (in_byte_ff == SYNC_LEAD) begin
                     phase_in = PH_AFTER;
                  end else begin
                     end_iter = 1'b1;
                  end
               end
               PH_AFTER: begin
                  if (in_byte_ff == SYNC_LEAD) begin
                     phase_in = PH_AFTER;
                  end else if (is_sync_code(in_byte_ff)) begin
                     held_sync_we = 1'b1;
                     phase_in     = PH_RATE;
                  end else begin
                     end_iter = 1'b1;
                  end
               end
               PH_RATE: begin
                  held_rate_we = 1'b1;
                  phase_in     = PH_MODE;
               end
               PH_MODE: begin
                  phase_in = PH_HUNT;
                  if (hdr_info.valid) begin
                     finished_in   = 1'b1;
                     out_valid_in  = 1'b1;
                     out_load      = 1'b1;
                     out_status_in = STATUS_FOUND;
                     out_chan_in   = hdr_info.channels;
                     out_freq_in   = hdr_info.frequency_hz;
                     out_brate_in  = hdr_info.byte_rate;
                     out_mp3_in    = hdr_info.is_mp3;
                     out_sync_in   = held_sync_ff;
                     out_rate_in   = held_rate_ff;
                     out_mode_in   = in_byte_ff;
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase

            if (end_iter) begin
               phase_in = PH_HUNT;
               if (count_cur >= last_iter) begin
                  finished_in  = 1'b1;
                  out_valid_in = 1'b1;
                  out_load     = 1'b1;
               end else begin
                  count_in = count_cur + 16'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         in_start_ff   <= 1'b0;
         phase_ff      <= PH_HUNT;
         count_ff      <= 16'd0;
         held_sync_ff  <= 8'd0;
         held_rate_ff  <= 8'd0;
         finished_ff   <= 1'b0;
         scan_limit_ff <= SCAN_LIMIT_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
            in_start_ff <= req_tuser;
            in_byte_ff  <= req_tdata;
         end
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         finished_ff <= finished_in;
         if (held_sync_we) begin
            held_sync_ff <= held_sync_in;
         end
         if (held_rate_we) begin
            held_rate_ff <= held_rate_in;
         end
         if (csr_wr_en) begin
            scan_limit_ff <= csr_wr_data;
         end
         out_valid_ff <= out_valid_in;
         if (out_load) begin
            out_status_ff <= out_status_in;
            out_chan_ff   <= out_chan_in;
            out_freq_ff   <= out_freq_in;
            out_brate_ff  <= out_brate_in;
            out_mp3_ff    <= out_mp3_in;
            out_sync_ff   <= out_sync_in;
            out_rate_ff   <= out_rate_in;
            out_mode_ff   <= out_mode_in;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {5'd0, out_mode_ff, out_rate_ff, out_sync_ff, out_mp3_ff,
                        out_brate_ff, out_freq_ff, out_chan_ff};

   `MAHSP_ASSERT(a_found_has_rates, clock, reset,
      (rsp_tvalid && rsp_tuser == STATUS_FOUND) |->
         (rsp_tdata[17:2] != 16'd0 && rsp_tdata[33:18] != 16'd0))
   `MAHSP_ASSERT(a_not_found_is_blank, clock, reset,
      (rsp_tvalid && rsp_tuser == STATUS_NOT_FOUND) |-> (rsp_tdata == 64'd0))
   `MAHSP_ASSERT(a_result_sets_finished, clock, reset,
      $rose(rsp_tvalid) |-> finished_ff)
   `MAHSP_ASSERT(a_stall_only_on_full_pipe, clock, reset,
      !req_tready |-> (in_valid_ff && rsp_tvalid && !rsp_tready))

endmodule

`default_nettype wire
